FILE: hw/rtl/aeg_pkg.sv
// ----------------------------------------------------------------------------
// aeg_pkg: shared types and constants
// constants, payload structs and codes for the envelope gain core
// ----------------------------------------------------------------------------
package aeg_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int GAIN_FRAC_BITS = 16;
   localparam int SCALE_BITS     = 15;
   localparam int GAIN_BITS      = SCALE_BITS + GAIN_FRAC_BITS;
   localparam int STEP_BITS      = 31;
   localparam int LEVEL_BITS     = 15;
   localparam int CSR_DATA_BITS  = 31;
   localparam int CSR_ADDR_BITS  = 2;
   localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS;
   localparam int SCALED_BITS    = PROD_BITS - GAIN_FRAC_BITS;
   localparam int QUOT_BITS      = SAMPLE_BITS + 1;

   localparam logic [SCALE_BITS-1:0] FULL_SCALE = 15'h7fff;
   localparam logic [GAIN_BITS-1:0]  FULL_GAIN  = {FULL_SCALE, {GAIN_FRAC_BITS{1'b0}}};

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ACT_SAMPLE   = 2'd0,
      ACT_NOTE_ON  = 2'd1,
      ACT_NOTE_OFF = 2'd2
   } action_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_ATTACK_STEP   = 2'd0,
      CSR_DECAY_STEP    = 2'd1,
      CSR_SUSTAIN_LEVEL = 2'd2,
      CSR_RELEASE_STEP  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                    action;
      logic signed [SAMPLE_BITS-1:0] sample_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      phase_type                     phase;
   } rsp_type;

   // one sample waiting to be scaled
   typedef struct packed {
      logic                   neg;
      logic [SAMPLE_BITS-1:0] mag;
      logic [GAIN_BITS-1:0]   gain;
      phase_type              phase;
   } work_type;

endpackage

FILE: hw/rtl/aeg_front.sv
// ----------------------------------------------------------------------------
// aeg_front: envelope state and item intake
// holds the settings and the gain/phase state, emits one work item per sample
// ----------------------------------------------------------------------------
module aeg_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [aeg_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [aeg_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                              accept,
   input  aeg_pkg::req_type                  req_data,
   output logic                              work_push,
   output aeg_pkg::work_type                 work_data
);
   import aeg_pkg::*;

   logic [STEP_BITS-1:0]  attack_step_ff;
   logic [STEP_BITS-1:0]  decay_step_ff;
   logic [LEVEL_BITS-1:0] sustain_level_ff;
   logic [STEP_BITS-1:0]  release_step_ff;
   logic [GAIN_BITS-1:0]  gain_ff;
   logic [GAIN_BITS-1:0]  gain_in;
   phase_type             phase_ff;
   phase_type             phase_in;
   logic [GAIN_BITS:0]    attack_sum;
   logic [GAIN_BITS-1:0]  decay_diff;
   logic [GAIN_BITS-1:0]  release_diff;
   logic [GAIN_BITS-1:0]  sustain_gain;
   logic                  is_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_step_ff   <= 31'd44737877;
         decay_step_ff    <= '0;
         sustain_level_ff <= FULL_SCALE;
         release_step_ff  <= 31'd44737877;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_ATTACK_STEP:   attack_step_ff   <= csr_wdata[STEP_BITS-1:0];
            CSR_DECAY_STEP:    decay_step_ff    <= csr_wdata[STEP_BITS-1:0];
            CSR_SUSTAIN_LEVEL: sustain_level_ff <= csr_wdata[LEVEL_BITS-1:0];
            CSR_RELEASE_STEP:  release_step_ff  <= csr_wdata[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign attack_sum   = {1'b0, gain_ff} + {1'b0, attack_step_ff};
   assign decay_diff   = gain_ff - decay_step_ff;
   assign release_diff = gain_ff - release_step_ff;
   assign sustain_gain = {sustain_level_ff, {GAIN_FRAC_BITS{1'b0}}};
   assign is_sample    = (req_data.action == ACT_SAMPLE);

   // next state
   always_comb begin
      gain_in  = gain_ff;
      phase_in = phase_ff;
      unique case (req_data.action)
         ACT_NOTE_ON:  phase_in = PH_ATTACK;
         ACT_NOTE_OFF: phase_in = PH_RELEASE;
         ACT_SAMPLE: begin
            unique case (phase_ff)
               PH_ATTACK: begin
                  if (attack_sum > {1'b0, FULL_GAIN}) begin
                     gain_in  = FULL_GAIN;
                     phase_in = PH_DECAY;
                  end else begin
                     gain_in = attack_sum[GAIN_BITS-1:0];
                  end
               end
               PH_DECAY: begin
                  if (decay_step_ff > gain_ff) begin
                     gain_in  = '0;
                     phase_in = PH_SUSTAIN;
                  end else begin
                     gain_in = decay_diff;
                     if (decay_diff < sustain_gain) begin
                        phase_in = PH_SUSTAIN;
                     end
                  end
               end
               PH_SUSTAIN: ;
               PH_RELEASE: begin
                  if (release_step_ff > gain_ff) begin
                     gain_in  = '0;
                     phase_in = PH_IDLE;
                  end else begin
                     gain_in = release_diff;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
         default: ;
      endcase
   end

   // outputs: sign and magnitude, the gain before its step, the phase after it
   always_comb begin
      work_push       = accept && is_sample;
      work_data.neg   = req_data.sample_in[SAMPLE_BITS-1];
      work_data.mag   = work_data.neg ? (~req_data.sample_in + 1'b1)
                                      : req_data.sample_in;
      work_data.gain  = (phase_ff == PH_IDLE) ? '0 : gain_ff;
      work_data.phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= '0;
         phase_ff <= PH_IDLE;
      end else if (accept) begin
         gain_ff  <= gain_in;
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: hw/rtl/aeg_queue.sv
// ----------------------------------------------------------------------------
// aeg_queue: work item queue
// short first-in first-out buffer between intake and scaling
// ----------------------------------------------------------------------------
module aeg_queue #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  aeg_pkg::work_type          push_data,
   input  logic                       pop,
   output aeg_pkg::work_type          head_data,
   output logic                       q_full,
   output logic                       q_empty,
   output logic [$clog2(DEPTH+1)-1:0] q_count
);
   import aeg_pkg::*;

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

   work_type            mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;

   assign q_full    = (count_ff == CNT_BITS'(DEPTH));
   assign q_empty   = (count_ff == '0);
   assign q_count   = count_ff;
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

FILE: hw/rtl/aeg_back.sv
// ----------------------------------------------------------------------------
// aeg_back: sample scaling pipeline
// multiplies by the gain, divides by full scale, holds the result for pop
// ----------------------------------------------------------------------------
module aeg_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  aeg_pkg::work_type head_data,
   output logic              q_pop,
   input  logic              pop,
   output logic              empty,
   output aeg_pkg::rsp_type  rsp_data
);
   import aeg_pkg::*;

   logic                    a_valid_ff;
   logic [SCALED_BITS-1:0]  a_scaled_ff;
   logic                    a_neg_ff;
   phase_type               a_phase_ff;
   logic                    b_valid_ff;
   rsp_type                 b_data_ff;
   rsp_type                 b_data_in;
   logic                    adv_a;
   logic                    adv_b;
   logic [PROD_BITS-1:0]    prod;
   logic [SAMPLE_BITS-1:0]  hi;
   logic [QUOT_BITS-1:0]    lo_sum;
   logic [QUOT_BITS-1:0]    quot;
   logic [QUOT_BITS-1:0]    signed_quot;

   assign adv_b = !b_valid_ff || pop;
   assign adv_a = !a_valid_ff || adv_b;
   assign q_pop = !q_empty && adv_a;

   // stage a: product scaled down by the fraction bits
   assign prod = PROD_BITS'(head_data.mag) * PROD_BITS'(head_data.gain);

   // stage b: divide by full scale, x = hi*2^15 + lo = hi*0x7fff + (hi + lo)
   assign hi     = a_scaled_ff[SCALED_BITS-1:SCALE_BITS];
   assign lo_sum = QUOT_BITS'(hi) + QUOT_BITS'(a_scaled_ff[SCALE_BITS-1:0]);

   always_comb begin
      quot = QUOT_BITS'(hi);
      if (lo_sum >= QUOT_BITS'({FULL_SCALE, 1'b0})) begin
         quot = QUOT_BITS'(hi) + QUOT_BITS'(2);
      end else if (lo_sum >= QUOT_BITS'(FULL_SCALE)) begin
         quot = QUOT_BITS'(hi) + QUOT_BITS'(1);
      end
      signed_quot          = a_neg_ff ? (~quot + 1'b1) : quot;
      b_data_in.sample_out = signed_quot[SAMPLE_BITS-1:0];
      b_data_in.phase      = a_phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (adv_a) begin
            a_valid_ff <= q_pop;
         end
         if (adv_b) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         a_scaled_ff <= prod[PROD_BITS-1:GAIN_FRAC_BITS];
         a_neg_ff    <= head_data.neg;
         a_phase_ff  <= head_data.phase;
      end
      if (adv_b) begin
         b_data_ff <= b_data_in;
      end
   end

   assign empty    = !b_valid_ff;
   assign rsp_data = b_data_ff;

endmodule

FILE: hw/rtl/adsr_envelope_gain_core.sv
// ----------------------------------------------------------------------------
// adsr_envelope_gain_core: attack-decay-sustain-release gain on audio samples
// takes samples and note events, returns each sample scaled by the envelope
// ----------------------------------------------------------------------------
// One item is taken per clock while full is low: the envelope gain moves by
// a single add and compare in the intake stage, so a sample or a note event
// can follow in the very next cycle. Note on and note off change the phase
// and give no result. A sample transfer gives one result that passes the
// queue write, then multiply, then divide by full scale, and waits at the
// result ports until popped. The queue holds QUEUE_DEPTH samples; full rises
// only when it and the two scaling stages are all occupied. The gain is
// unsigned Q15.16, the result is sample * gain / (0x7fff * 2^16) truncated
// toward zero. Settings are to be written through csr_we/csr_addr/csr_wdata
// only while idle; the block itself does not enforce this.
module adsr_envelope_gain_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   // input queue side
   input  logic                              push,
   output logic                              full,
   input  aeg_pkg::req_type                  req_data,
   // result queue side
   output logic                              empty,
   input  logic                              pop,
   output aeg_pkg::rsp_type                  rsp_data,
   // settings write port
   input  logic                              csr_we,
   input  logic [aeg_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [aeg_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import aeg_pkg::*;

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic                accept;
   logic                work_push;
   work_type            work_data;
   work_type            head_data;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;
   logic [CNT_BITS-1:0] q_count;

   // an item transfers whenever the queue has room
   assign full   = q_full;
   assign accept = push && !q_full;

   // intake: settings, envelope state, one work item per sample
   aeg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_data  (req_data),
      .work_push (work_push),
      .work_data (work_data)
   );

   // decouples intake from scaling
   aeg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work_data),
      .pop       (q_pop),
      .head_data (head_data),
      .q_full    (q_full),
      .q_empty   (q_empty),
      .q_count   (q_count)
   );

   // scaling pipeline with result register
   aeg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head_data (head_data),
      .q_pop     (q_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a waiting result stays put until it is popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed before its transfer");

   // queue occupancy rises on a push without a pop
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (work_push && !q_pop) |=> (q_count == $past(q_count) + 1'b1))
      else $error("queue count missed a push");

   // nothing pending and room for items straight after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (empty && !full && q_count == '0))
      else $error("block not clear after reset");
`endif

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the envelope gain core
// feeds note events and audio samples through the input queue, predicts the
// scaled sample and envelope phase of every sample transfer, and checks each
// result popped from the output queue against that prediction
// ----------------------------------------------------------------------------
module tb_top;
   import aeg_pkg::*;

   // stimulus operations seen by the driver
   typedef enum logic [1:0] {
      OP_ITEM,
      OP_CSR,
      OP_DRAIN,
      OP_HOLD
   } stim_kind_type;

   typedef struct {
      stim_kind_type kind;
      req_type       req;
      csr_index_type idx;
      logic [CSR_DATA_BITS-1:0] val;
   } stim_op_type;

   // action code that the core must ignore
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam int unsigned LIMIT_CYCLES  = 400000;
   localparam int unsigned SETTLE_CYCLES = 8;    // pipeline quiet time before a csr write
   localparam int unsigned TAIL_CYCLES   = 20;
   localparam int unsigned HOLD_CYCLES   = 300;  // long receiver hold-off
   localparam int unsigned RAND_PHASES   = 7;
   localparam int unsigned PHASE_ITEMS   = 110;

   localparam logic [63:0] FULL_GAIN64 = 64'(FULL_GAIN);
   // release step that reaches zero exactly from full gain in seven samples
   localparam logic [CSR_DATA_BITS-1:0] EXACT_RELEASE = 31'd306774016;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // core ports, inputs all known from time zero
   logic                     push      = 1'b0;
   logic                     full;
   req_type                  req_data  = '0;
   logic                     empty;
   logic                     pop       = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_we    = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr  = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // envelope model state and its copy of the settings
   logic [63:0] env_gain;
   phase_type   env_ph;
   logic [63:0] cfg_attack, cfg_decay, cfg_sustain, cfg_release;

   // stimulus and expected scaled samples
   stim_op_type stim_ops[$];
   rsp_type     pending_scaled[$];

   // driver / monitor handshakes inside the bench
   logic        hold_go    = 1'b0;
   bit          stim_done  = 1'b0;

   // bookkeeping for the end-of-run summary
   int unsigned cycle_cnt   = 0;
   int unsigned n_errors    = 0;
   int unsigned n_samples   = 0;
   int unsigned n_notes     = 0;
   int unsigned n_ignored   = 0;
   int unsigned n_results   = 0;
   int unsigned n_settings  = 0;
   int unsigned full_cycles = 0;
   logic [7:0]  phases_seen = '0;

   adsr_envelope_gain_core dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // run limit, counted in clock cycles
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // envelope prediction
   // ------------------------------------------------------------------------

   // sample * gain / full gain, truncated toward zero
   function automatic logic [SAMPLE_BITS-1:0] scale_by_gain(logic [SAMPLE_BITS-1:0] s,
                                                            logic [63:0] g);
      logic [63:0] mag, q, res;
      mag = s[SAMPLE_BITS-1] ? (64'd1 << SAMPLE_BITS) - 64'(s) : 64'(s);
      q   = (mag * g) / FULL_GAIN64;
      res = s[SAMPLE_BITS-1] ? (64'd0 - q) : q;
      return res[SAMPLE_BITS-1:0];
   endfunction

   function void write_envelope_cfg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] v);
      case (idx)
         CSR_ATTACK_STEP:   cfg_attack  = 64'(v);
         CSR_DECAY_STEP:    cfg_decay   = 64'(v);
         CSR_SUSTAIN_LEVEL: cfg_sustain = 64'(v[LEVEL_BITS-1:0]);
         CSR_RELEASE_STEP:  cfg_release = 64'(v);
         default: ;
      endcase
   endfunction

   // one accepted input transfer: move the envelope and queue any result
   function void advance_envelope(req_type r);
      rsp_type                o;
      logic [SAMPLE_BITS-1:0] y;
      y = '0;
      case (r.action)
         ACT_NOTE_ON: begin
            env_ph = PH_ATTACK;
            n_notes++;
         end
         ACT_NOTE_OFF: begin
            env_ph = PH_RELEASE;
            n_notes++;
         end
         ACT_SAMPLE: begin
            n_samples++;
            case (env_ph)
               PH_ATTACK: begin
                  y = scale_by_gain(r.sample_in, env_gain);
                  env_gain = env_gain + cfg_attack;
                  // overshoot clamps to full scale and starts decay
                  if (env_gain > FULL_GAIN64) begin
                     env_gain = FULL_GAIN64;
                     env_ph   = PH_DECAY;
                  end
               end
               PH_DECAY: begin
                  y = scale_by_gain(r.sample_in, env_gain);
                  if (cfg_decay > env_gain) begin
                     env_gain = '0;
                     env_ph   = PH_SUSTAIN;
                  end else begin
                     env_gain = env_gain - cfg_decay;
                     if (env_gain < (cfg_sustain << GAIN_FRAC_BITS))
                        env_ph = PH_SUSTAIN;
                  end
               end
               PH_SUSTAIN: y = scale_by_gain(r.sample_in, env_gain);
               PH_RELEASE: begin
                  y = scale_by_gain(r.sample_in, env_gain);
                  // landing exactly on zero stays in release for one more sample
                  if (cfg_release > env_gain) begin
                     env_gain = '0;
                     env_ph   = PH_IDLE;
                  end else begin
                     env_gain = env_gain - cfg_release;
                  end
               end
               default: begin
                  env_ph = PH_IDLE;
                  y      = '0;
               end
            endcase
            o.sample_out = y;
            o.phase      = env_ph;
            pending_scaled.push_back(o);
            phases_seen[env_ph] = 1'b1;
         end
         default: n_ignored++;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------------

   function void add_item(logic [1:0] act, logic [SAMPLE_BITS-1:0] s);
      stim_op_type op;
      op.kind = OP_ITEM;
      op.req.action    = act;
      op.req.sample_in = s;
      op.idx = CSR_ATTACK_STEP;
      op.val = '0;
      stim_ops.push_back(op);
   endfunction

   function void add_ctrl(stim_kind_type k, csr_index_type idx, logic [CSR_DATA_BITS-1:0] v);
      stim_op_type op;
      op.kind = k;
      op.req  = '0;
      op.idx  = idx;
      op.val  = v;
      stim_ops.push_back(op);
   endfunction

   // wait for the core to go quiet, then write all four settings
   function void add_settings(logic [CSR_DATA_BITS-1:0] atk, logic [CSR_DATA_BITS-1:0] dec,
                              logic [LEVEL_BITS-1:0] lvl, logic [CSR_DATA_BITS-1:0] rel);
      add_ctrl(OP_DRAIN, CSR_ATTACK_STEP, '0);
      add_ctrl(OP_CSR, CSR_ATTACK_STEP, atk);
      add_ctrl(OP_CSR, CSR_DECAY_STEP, dec);
      add_ctrl(OP_CSR, CSR_SUSTAIN_LEVEL, 31'(lvl));
      add_ctrl(OP_CSR, CSR_RELEASE_STEP, rel);
      n_settings++;
   endfunction

   function logic [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // steps mostly sized so that a phase lasts a few dozen samples
   function logic [CSR_DATA_BITS-1:0] rand_step();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 31'h7fffffff;
         2:       return 31'($urandom);
         default: return 31'(32'h7fff0000 / $urandom_range(2, 60));
      endcase
   endfunction

   function logic [LEVEL_BITS-1:0] rand_level();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return 15'h7fff;
         default: return 15'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // driver: bursts of input transfers with random gaps
   // ------------------------------------------------------------------------
   int unsigned gap_left    = 0;
   int unsigned burst_left  = 0;
   int unsigned settle_left = 0;

   always @(posedge clock) begin : drive
      logic        nxt_push, nxt_we, nxt_hold;
      stim_op_type op;
      if (reset) begin
         push    <= 1'b0;
         csr_we  <= 1'b0;
         hold_go <= 1'b0;
         env_gain    = '0;
         env_ph      = PH_IDLE;
         cfg_attack  = 64'd44737877;
         cfg_decay   = 64'd0;
         cfg_sustain = 64'd32767;
         cfg_release = 64'd44737877;
      end else begin
         // bookkeeping for what happened at this edge
         if (push && !full)
            advance_envelope(req_data);
         if (push && full)
            full_cycles++;
         if (csr_we)
            write_envelope_cfg(csr_index_type'(csr_addr), csr_wdata);

         nxt_push = 1'b0;
         nxt_we   = 1'b0;
         nxt_hold = 1'b0;
         if (push && full) begin
            // keep offering the same item until it is taken
            nxt_push = 1'b1;
         end else if (settle_left > 0) begin
            settle_left--;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (stim_ops.size() == 0) begin
            stim_done = 1'b1;
         end else begin
            op = stim_ops[0];
            case (op.kind)
               OP_ITEM: begin
                  nxt_push = 1'b1;
                  req_data <= op.req;
                  void'(stim_ops.pop_front());
                  // end of burst: pick a gap and the next burst length
                  if (burst_left == 0) begin
                     burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 16);
                     gap_left   = $urandom_range(1, 8);
                  end else begin
                     burst_left--;
                  end
               end
               OP_CSR: begin
                  nxt_we = 1'b1;
                  csr_addr  <= op.idx;
                  csr_wdata <= op.val;
                  void'(stim_ops.pop_front());
               end
               OP_DRAIN: begin
                  // sender pauses until every expected result has been popped
                  if (pending_scaled.size() == 0) begin
                     settle_left = SETTLE_CYCLES;
                     void'(stim_ops.pop_front());
                  end
               end
               default: begin
                  nxt_hold = 1'b1;
                  void'(stim_ops.pop_front());
               end
            endcase
         end
         push    <= nxt_push;
         csr_we  <= nxt_we;
         hold_go <= nxt_hold;
      end
   end

   // ------------------------------------------------------------------------
   // monitor: pops results on its own stall pattern and checks them
   // ------------------------------------------------------------------------
   int unsigned hold_left = 0;
   int unsigned slot_left = 0;
   logic [7:0]  pop_pattern = '1;

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            n_results++;
            if (pending_scaled.size() == 0) begin
               n_errors++;
               $error("unexpected result: sample_out %0d, phase %0d",
                      rsp_data.sample_out, rsp_data.phase);
            end else begin
               want = pending_scaled.pop_front();
               if (rsp_data.sample_out !== want.sample_out) begin
                  n_errors++;
                  $error("sample_out: expected %0d, got %0d",
                         want.sample_out, rsp_data.sample_out);
               end
               if (rsp_data.phase !== want.phase) begin
                  n_errors++;
                  $error("phase: expected %0d, got %0d", want.phase, rsp_data.phase);
               end
            end
         end

         if (hold_go)
            hold_left = HOLD_CYCLES;

         // new stall pattern once every slot of the last one is used: free running, random or sparse
         if (slot_left == 0) begin
            case ($urandom_range(0, 2))
               0:       pop_pattern = '1;
               1:       pop_pattern = 8'($urandom);
               default: pop_pattern = 8'($urandom) & 8'($urandom);
            endcase
            slot_left = 8;
         end
         slot_left--;

         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= pop_pattern[slot_left];
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus plan and end of run
   // ------------------------------------------------------------------------
   initial begin : run
      int unsigned ph_items, n, k;
      logic [1:0]  act;

      // directed part under the reset settings
      add_item(ACT_SAMPLE, 16'h7fff);        // idle gives zero
      add_item(ACT_NOTE_OFF, 16'h1234);      // note off while idle
      add_item(ACT_SAMPLE, 16'h8000);        // release from zero gain, back to idle
      add_item(ACT_UNUSED, 16'hffff);        // ignored action
      add_item(ACT_NOTE_ON, 16'h0000);
      add_item(ACT_SAMPLE, 16'h8000);
      add_item(ACT_SAMPLE, 16'h7fff);
      add_item(ACT_SAMPLE, 16'h0000);
      add_item(ACT_SAMPLE, 16'hffff);
      add_item(ACT_SAMPLE, 16'h0001);
      add_item(ACT_NOTE_ON, 16'h5555);       // note on in attack keeps the gain
      add_item(ACT_SAMPLE, 16'h4000);
      add_item(ACT_SAMPLE, 16'hc000);
      add_item(ACT_UNUSED, 16'haaaa);
      add_item(ACT_NOTE_OFF, 16'h0000);
      add_item(ACT_SAMPLE, 16'h8000);
      add_item(ACT_SAMPLE, 16'h7fff);
      add_item(ACT_SAMPLE, 16'h8001);
      add_item(ACT_UNUSED, 16'h0000);
      add_item(ACT_SAMPLE, 16'h2aaa);

      // extremes: attack clamps at once, decay underflows, release underflows
      add_settings(31'h7fffffff, 31'h7fffffff, 15'h0000, 31'h7fffffff);
      add_item(ACT_NOTE_ON, 16'h0000);
      repeat (3) add_item(ACT_SAMPLE, rand_sample());
      add_item(ACT_NOTE_OFF, 16'hffff);
      repeat (3) add_item(ACT_SAMPLE, rand_sample());

      // release landing exactly on zero, decay held at full scale
      add_settings(31'h7fffffff, 31'h0, 15'h7fff, EXACT_RELEASE);
      add_item(ACT_NOTE_ON, 16'h0000);
      repeat (3) add_item(ACT_SAMPLE, 16'h7fff);
      add_item(ACT_NOTE_OFF, 16'h0000);
      repeat (10) add_item(ACT_SAMPLE, 16'h8000);

      // all steps zero: the envelope never moves
      add_settings(31'h0, 31'h0, 15'h7fff, 31'h0);
      add_item(ACT_NOTE_ON, 16'h0000);
      repeat (3) add_item(ACT_SAMPLE, rand_sample());
      add_item(ACT_NOTE_OFF, 16'h0000);
      repeat (3) add_item(ACT_SAMPLE, rand_sample());

      // random part: mostly whole notes with random content, some noise
      for (int p = 0; p < RAND_PHASES; p++) begin
         add_settings(rand_step(), rand_step(), rand_level(), rand_step());
         // long hold-off on the result side while items keep coming
         if (p == 1 || p == 4)
            add_ctrl(OP_HOLD, CSR_ATTACK_STEP, '0);
         ph_items = 0;
         while (ph_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
               add_item(ACT_NOTE_ON, rand_sample());
               n = $urandom_range(1, 70);
               repeat (n) add_item(ACT_SAMPLE, rand_sample());
               add_item(ACT_NOTE_OFF, rand_sample());
               k = $urandom_range(1, 40);
               repeat (k) add_item(ACT_SAMPLE, rand_sample());
               ph_items += n + k + 2;
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  act = 2'($urandom_range(0, 3));
                  add_item(act, rand_sample());
                  if (act != ACT_UNUSED)
                     ph_items++;
               end
            end
         end
      end

      // hold reset, then let the driver and monitor run
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (!(stim_done && pending_scaled.size() == 0))
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d samples, %0d note events, %0d ignored items, %0d results, %0d settings",
               n_samples, n_notes, n_ignored, n_results, n_settings);
      $display("phases reached (bit per phase) %b, %0d cycles with push held off by full",
               phases_seen[4:0], full_cycles);
      if (n_errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/aeg_pkg.sv
hw/rtl/aeg_front.sv
hw/rtl/aeg_queue.sv
hw/rtl/aeg_back.sv
hw/rtl/adsr_envelope_gain_core.sv
tb/tb_top.sv
